// ----- rtl/wswm_pkg.sv -----
// Package with field widths, the schedule entry layout and the window compare.
`timescale 1ns / 1ps
`default_nettype none

package wswm_pkg;

  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned CountWidth        = 5;
  localparam int unsigned IndexWidth        = 4;
  localparam int unsigned MinuteOfDayWidth  = 11;
  localparam int unsigned InDataWidth       = 56;
  localparam int unsigned OutDataWidth      = 8;
  localparam int unsigned EntryWidth        = 30;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic [MinuteOfDayWidth-1:0] end_min;
    logic [MinuteOfDayWidth-1:0] start_min;
    logic [6:0]                  days;
    logic                        enabled;
  } sched_entry_t;

  function automatic logic window_holds(input logic [MinuteOfDayWidth-1:0] s,
                                        input logic [MinuteOfDayWidth-1:0] e,
                                        input logic [MinuteOfDayWidth-1:0] now);
    logic res;
    if (s == e) begin
      res = 1'b0;
    end else if (s < e) begin
      res = (now >= s) && (now < e);
    end else begin
      res = (now >= s) || (now < e);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wswm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module wswm_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/weekly_schedule_window_match_core.sv -----
// Top level of the weekly schedule window matcher: table writes and first-match queries.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: op; tdata: entry and clock fields of one item
//   m_axis    out        tdata: found, active_index
//   cfg       in         cfg_data_i: entry_count
//
// A write beat stores its entry in the table RAM.
// A query beat scans the table from entry 0: the single RAM read port yields
// one entry per cycle, and the scan stops at the first matching entry or at the entry count.
// Reset clears one valid flop per entry, so an unwritten entry reads as disabled.
// The result sits in an output register; a new beat is accepted while it waits,
// and a finished scan holds until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module weekly_schedule_window_match_core
  import wswm_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata fields from bit 0: entry_index, entry_enabled, entry_days, entry_start_minute,
  // entry_end_minute, clock_weekday, clock_hour, clock_minute, time_valid.
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  // tuser fields from bit 0: op.
  input  wire logic                    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // tdata fields from bit 0: found, active_index.
  output logic [OutDataWidth-1:0]      m_axis_tdata,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CountWidth-1:0]   cfg_data_i
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e                      state_q, state_d;
  logic [MAX_ENTRIES-1:0]      valid_q, valid_d;
  logic [CountWidth-1:0]       count_q, count_d;
  logic [CW-1:0]               ptr_q, ptr_d;
  logic [CW-1:0]               limit_q, limit_d;
  logic [MinuteOfDayWidth-1:0] now_q, now_d;
  logic [2:0]                  day_q, day_d;
  logic                        res_found_q, res_found_d;
  logic [IndexWidth-1:0]       res_idx_q, res_idx_d;
  logic                        m_valid_q, m_valid_d;
  logic [OutDataWidth-1:0]     m_data_q, m_data_d;

  logic [IndexWidth-1:0]       in_idx;
  logic [2:0]                  in_wday;
  logic [4:0]                  in_hour;
  logic [5:0]                  in_minute;
  logic                        in_tv;
  sched_entry_t                in_entry;
  sched_entry_t                rd_entry;
  logic                        time_ok;
  logic [MinuteOfDayWidth-1:0] in_now;
  logic [CW-1:0]               in_limit;
  logic [CW-1:0]               ptr_nxt;
  logic                        accept;
  logic                        wr_en;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic                        hit;
  logic                        out_free;

  assign in_idx             = s_axis_tdata[3:0];
  assign in_entry.enabled   = s_axis_tdata[4];
  assign in_entry.days      = s_axis_tdata[11:5];
  assign in_entry.start_min = s_axis_tdata[22:12];
  assign in_entry.end_min   = s_axis_tdata[33:23];
  assign in_wday            = s_axis_tdata[36:34];
  assign in_hour            = s_axis_tdata[41:37];
  assign in_minute          = s_axis_tdata[47:42];
  assign in_tv              = s_axis_tdata[48];

  assign time_ok = in_tv && (in_hour <= 5'd23) && (in_minute <= 6'd59) && (in_wday < 3'd7);
  assign in_now  = {in_hour, 6'b0} - {4'b0, in_hour, 2'b0} + {5'b0, in_minute};
  assign in_limit = ({{(32-CountWidth){1'b0}}, count_q} > MAX_ENTRIES) ?
                    CW'(MAX_ENTRIES) : CW'(count_q);

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = accept && (s_axis_tuser == OpWrite) &&
                         ({{(32-IndexWidth){1'b0}}, in_idx} < MAX_ENTRIES);
  assign waddr         = AW'(in_idx);
  assign ptr_nxt       = ptr_q + CW'(1);
  assign raddr         = (state_q == StScan) ? ptr_nxt[AW-1:0] : '0;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign hit = valid_q[ptr_q[AW-1:0]] && rd_entry.enabled && rd_entry.days[day_q] &&
               window_holds(rd_entry.start_min, rd_entry.end_min, now_q);

  wswm_ram #(
    .Width (EntryWidth),
    .Depth (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (in_entry),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    limit_d     = limit_q;
    now_d       = now_q;
    day_d       = day_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;

    if (cfg_valid_i) begin
      count_d = cfg_data_i;
    end
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (wr_en) begin
      valid_d[waddr] = 1'b1;
    end

    unique case (state_q)
      StIdle: begin
        if (accept && (s_axis_tuser == OpQuery)) begin
          ptr_d       = '0;
          limit_d     = in_limit;
          now_d       = in_now;
          day_d       = (in_wday == 3'd0) ? 3'd6 : in_wday - 3'd1;
          res_found_d = 1'b0;
          res_idx_d   = '0;
          if (!time_ok || (in_limit == '0)) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_idx_d   = IndexWidth'(ptr_q);
          state_d     = StDone;
        end else if (ptr_nxt == limit_q) begin
          state_d = StDone;
        end else begin
          ptr_d = ptr_nxt;
        end
      end
      StDone: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(OutDataWidth-IndexWidth-1){1'b0}}, res_idx_q, res_found_q};
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      limit_q     <= '0;
      now_q       <= '0;
      day_q       <= '0;
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      limit_q     <= limit_d;
      now_q       <= now_d;
      day_q       <= day_d;
      res_found_q <= res_found_d;
      res_idx_q   <= res_idx_d;
      m_valid_q   <= m_valid_d;
      m_data_q    <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_notfound_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == '0))
    else $error("not-found result carries a nonzero index");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (ptr_q < limit_q))
    else $error("scan pointer beyond the entry limit");

  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == OpQuery)) |=> !s_axis_tready)
    else $error("new beat accepted while a query is in progress");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == OpWrite) && !m_valid_q) |=> !m_valid_q)
    else $error("write beat produced a result");

endmodule

`default_nettype wire

// ----- tb/weekly_schedule_window_match_checker.sv -----
// Checker that mirrors the schedule table, predicts each lookup and compares the results.
`timescale 1ns / 1ps

module weekly_schedule_window_match_checker
  import wswm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [InDataWidth-1:0] s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CountWidth-1:0]  cfg_data_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            pending_count_o,
  output int unsigned            result_count_o,
  output int unsigned            hit_count_o
);

  typedef struct packed {
    logic                  found;
    logic [IndexWidth-1:0] index;
  } lookup_result_t;

  sched_entry_t          sched_mirror [MaxEntriesDefault];
  logic [CountWidth-1:0] entry_count_q;
  lookup_result_t        expected_lookups [$];

  function automatic logic window_covers(input logic [MinuteOfDayWidth-1:0] first,
                                         input logic [MinuteOfDayWidth-1:0] last,
                                         input logic [MinuteOfDayWidth-1:0] now);
    if (first == last) begin
      return 1'b0;
    end
    if (first < last) begin
      return (now >= first) && (now < last);
    end
    return (now >= first) || (now < last);
  endfunction

  function automatic lookup_result_t lookup_active(input logic [InDataWidth-1:0] beat);
    lookup_result_t              res;
    logic [2:0]                  wday;
    logic [4:0]                  hour;
    logic [5:0]                  minute;
    logic [2:0]                  day_bit;
    logic [MinuteOfDayWidth-1:0] now;
    int unsigned                 limit;
    res    = '0;
    wday   = beat[36:34];
    hour   = beat[41:37];
    minute = beat[47:42];
    if (!beat[48] || hour > 5'd23 || minute > 6'd59 || wday == 3'd7) begin
      return res;
    end
    // The clock counts weekdays from Sunday, the day mask from Monday.
    day_bit = (wday == 3'd0) ? 3'd6 : wday - 3'd1;
    now     = MinuteOfDayWidth'(32'(hour) * 60 + 32'(minute));
    limit   = 32'(entry_count_q);
    if (limit > MaxEntriesDefault) begin
      limit = MaxEntriesDefault;
    end
    for (int i = 0; i < limit; i++) begin
      if (sched_mirror[i].enabled && sched_mirror[i].days[day_bit] &&
          window_covers(sched_mirror[i].start_min, sched_mirror[i].end_min, now)) begin
        res.found = 1'b1;
        res.index = i[IndexWidth-1:0];
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    logic [3:0]     idx;
    if (!rst_ni) begin
      for (int i = 0; i < MaxEntriesDefault; i++) begin
        sched_mirror[i] = '0;
      end
      entry_count_q = '0;
      expected_lookups.delete();
      pending_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        entry_count_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OpWrite) begin
          idx = s_axis_tdata[3:0];
          sched_mirror[idx].enabled   = s_axis_tdata[4];
          sched_mirror[idx].days      = s_axis_tdata[11:5];
          sched_mirror[idx].start_min = s_axis_tdata[22:12];
          sched_mirror[idx].end_min   = s_axis_tdata[33:23];
        end else begin
          expected_lookups.push_back(lookup_active(s_axis_tdata));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count_o++;
        if (m_axis_tdata[0]) begin
          hit_count_o++;
        end
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual tdata %h",
                   $time, m_axis_tdata);
          mismatch_count_o++;
        end else begin
          want = expected_lookups.pop_front();
          if (m_axis_tdata[0] !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, m_axis_tdata[0]);
            mismatch_count_o++;
          end
          if (m_axis_tdata[4:1] !== want.index) begin
            $display("%0t: active_index mismatch, expected %0d, actual %0d",
                     $time, want.index, m_axis_tdata[4:1]);
            mismatch_count_o++;
          end
        end
      end
      pending_count_o = expected_lookups.size();
    end
  end

endmodule

// ----- tb/weekly_schedule_window_match_core_test.sv -----
// Top of the schedule matcher testbench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module weekly_schedule_window_match_core_test;
  import wswm_pkg::*;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata  = '0;
  logic                    s_axis_tuser  = OpWrite;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CountWidth-1:0]   cfg_data_i    = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned hits;
  int unsigned beats_sent    = 0;
  int unsigned counts_loaded = 0;
  logic        steady        = 1'b0;
  logic [CountWidth-1:0] count_plan [9] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17,
                                            5'd3, 5'd16, 5'd2, 5'd16};

  weekly_schedule_window_match_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  weekly_schedule_window_match_checker match_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending),
    .result_count_o   (results),
    .hit_count_o      (hits)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 13);
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [InDataWidth-1:0] pack_item(
      input logic [3:0] idx, input logic en, input logic [6:0] days,
      input logic [10:0] first, input logic [10:0] last, input logic [2:0] wday,
      input logic [4:0] hour, input logic [5:0] minute, input logic tv);
    return {7'b0, tv, minute, hour, wday, last, first, days, en, idx};
  endfunction

  task automatic push_beat(input logic op, input logic [InDataWidth-1:0] data);
    while (!steady && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    beats_sent++;
  endtask

  task automatic send_write(input logic [3:0] idx, input logic en, input logic [6:0] days,
                            input logic [10:0] first, input logic [10:0] last);
    logic [31:0] noise;
    noise = $urandom;
    push_beat(OpWrite, pack_item(idx, en, days, first, last, noise[2:0], noise[7:3],
                                 noise[13:8], noise[14]));
  endtask

  task automatic send_query(input logic [2:0] wday, input logic [4:0] hour,
                            input logic [5:0] minute, input logic tv);
    logic [31:0] noise;
    noise = $urandom;
    push_beat(OpQuery, pack_item(noise[3:0], noise[4], noise[11:5], noise[22:12],
                                 {noise[31:23], noise[1:0]}, wday, hour, minute, tv));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CountWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    counts_loaded++;
  endtask

  task automatic random_beat();
    logic [10:0] first;
    logic [10:0] last;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        tv;
    int unsigned sel;
    if ($urandom_range(99) < 30) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        first = 11'($urandom_range(2047));
        last  = 11'($urandom_range(2047));
      end else if (sel == 1) begin
        first = 11'($urandom_range(1439));
        last  = first;
      end else begin
        first = 11'($urandom_range(1439));
        last  = 11'($urandom_range(1439));
      end
      send_write(4'($urandom_range(15)), $urandom_range(9) != 0,
                 7'($urandom_range(127) | $urandom_range(127)), first, last);
    end else begin
      wday   = 3'($urandom_range(6));
      hour   = 5'($urandom_range(23));
      minute = 6'($urandom_range(59));
      tv     = 1'b1;
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(3))
          0: tv = 1'b0;
          1: wday = 3'd7;
          2: hour = 5'($urandom_range(31, 24));
          default: minute = 6'($urandom_range(63, 60));
        endcase
      end
      send_query(wday, hour, minute, tv);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_write(4'd0, 1'b1, 7'h7F, 11'd480, 11'd1020);
    send_write(4'd1, 1'b1, 7'h7F, 11'd1320, 11'd360);
    send_write(4'd2, 1'b1, 7'h7F, 11'd600, 11'd600);
    send_write(4'd3, 1'b0, 7'h7F, 11'd0, 11'd1439);
    send_write(4'd15, 1'b1, 7'h40, 11'd2047, 11'd30);
    send_query(3'd1, 5'd10, 6'd0, 1'b1);
    settle();
    write_count(5'd16);
    send_query(3'd1, 5'd10, 6'd0, 1'b1);
    send_query(3'd1, 5'd23, 6'd30, 1'b1);
    send_query(3'd1, 5'd3, 6'd0, 1'b1);
    send_query(3'd1, 5'd10, 6'd0, 1'b0);
    send_query(3'd7, 5'd10, 6'd0, 1'b1);
    send_query(3'd2, 5'd24, 6'd0, 1'b1);
    send_query(3'd2, 5'd31, 6'd0, 1'b1);
    send_query(3'd2, 5'd10, 6'd60, 1'b1);
    send_query(3'd2, 5'd10, 6'd63, 1'b1);
    send_write(4'd1, 1'b1, 7'h3F, 11'd1320, 11'd360);
    send_query(3'd0, 5'd0, 6'd10, 1'b1);
    send_query(3'd6, 5'd6, 6'd0, 1'b1);
    send_query(3'd1, 5'd8, 6'd0, 1'b1);
    send_query(3'd1, 5'd17, 6'd0, 1'b1);
    send_query(3'd4, 5'd23, 6'd59, 1'b1);

    count_plan[7] = CountWidth'($urandom_range(31));
    for (int p = 0; p < 9; p++) begin
      settle();
      write_count(count_plan[p]);
      steady <= (p == 4);
      for (int n = 0; n < 150; n++) begin
        random_beat();
      end
    end
    steady <= 1'b0;
    settle();

    $display("Summary: %0d input beats over %0d entry_count settings, %0d lookups checked",
             beats_sent, counts_loaded, results);
    $display("         (%0d of them hits), with random stalls on both channels.", hits);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
